>>> src/irpd_pkg.sv
// Shared types and constants for the infrared remote pulse decoder.
`default_nettype none
package irpd_pkg;

	localparam int unsigned IDX_W  = 3;
	localparam int unsigned DATA_W = 16;

	localparam logic [IDX_W-1:0] REG_ZERO_LOW  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ZERO_HIGH = 3'd1;
	localparam logic [IDX_W-1:0] REG_ONE_LOW   = 3'd2;
	localparam logic [IDX_W-1:0] REG_ONE_HIGH  = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAP       = 3'd4;
	localparam logic [IDX_W-1:0] REG_HOLD      = 3'd5;
	localparam logic [IDX_W-1:0] REG_SYNC_LOW  = 3'd6;

	localparam logic [15:0] RST_ZERO_LOW  = 16'd250;
	localparam logic [15:0] RST_ZERO_HIGH = 16'd550;
	localparam logic [15:0] RST_ONE_LOW   = 16'd900;
	localparam logic [15:0] RST_ONE_HIGH  = 16'd1400;
	localparam logic [15:0] RST_GAP       = 16'd1500;
	localparam logic [15:0] RST_HOLD      = 16'd300;
	localparam logic [5:0]  RST_SYNC_LOW  = 6'd50;

	localparam logic [4:0] FRAME_EDGES = 5'd24;
	localparam logic [4:0] HALF_EDGES  = 5'd12;

	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [15:0] zero_low_us;
		logic [15:0] zero_high_us;
		logic [15:0] one_low_us;
		logic [15:0] one_high_us;
		logic [15:0] gap_us;
		logic [15:0] hold_ms;
		logic [5:0]  sync_low;
	} cfg_t;

endpackage
`default_nettype wire

>>> src/ir_remote_pulse_decoder.sv
// Top level of the infrared remote pulse decoder: handshake, stage registers, core.
//
// Input words (kind, edge_interval_us, now_ms) arrive on in_valid/in_ready.
// kind 0 is a signal edge carrying the time since the previous edge; kind 1
// reads the current code and applies the hold-time and fresh-flag rules.
// Every input word produces exactly one output word (code, accepted) on
// out_valid/out_ready, in order.
// An accepted word lands in the input register, is decoded from there and its
// result is written to the output register. One word can be accepted in every
// cycle while the receiver does not stall; the decode is a single pass of
// compares and shifts between the two registers, which sets the throughput of
// one word per cycle.
// When the receiver stalls, the output register holds its word and the input
// register keeps one more; in_ready drops only while both are full.
// Configuration is written through cfg_we/cfg_index/cfg_data and takes effect
// for the next decoded word; write it only while the block is idle.
// Reset (arst_n low) empties both registers and returns all decoder state and
// registers to their defaults; no clearing pass is needed.
`default_nettype none
module ir_remote_pulse_decoder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       kind,
	input  wire logic [15:0]                edge_interval_us,
	input  wire logic [31:0]                now_ms,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [15:0]                     code,
	output logic                            accepted,
	input  wire logic                       cfg_we,
	input  wire logic [irpd_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [irpd_pkg::DATA_W-1:0] cfg_data
);

	irpd_pkg::cfg_t cfg;

	// Input stage register.
	logic        valid_s1;
	logic        kind_s1;
	logic [15:0] interval_s1;
	logic [31:0] now_s1;

	// Output register.
	logic        out_valid_q;
	logic [15:0] code_q;
	logic        accepted_q;

	logic        advance;
	logic [15:0] code_nx;
	logic        accepted_nx;

	// The stage word moves on whenever the output register is free or is
	// being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	irpd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	irpd_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.kind             (kind_s1),
		.edge_interval_us (interval_s1),
		.now_ms           (now_s1),
		.cfg              (cfg),
		.code_nx          (code_nx),
		.accepted_nx      (accepted_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1     <= kind;
			interval_s1 <= edge_interval_us;
			now_s1      <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_q     <= code_nx;
			accepted_q <= accepted_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign code      = code_q;
	assign accepted  = accepted_q;

endmodule
`default_nettype wire

>>> src/irpd_cfg_regs.sv
// Configuration register file of the infrared remote pulse decoder.
`default_nettype none
module irpd_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       we,
	input  wire logic [irpd_pkg::IDX_W-1:0]  index,
	input  wire logic [irpd_pkg::DATA_W-1:0] data,
	output irpd_pkg::cfg_t                  cfg
);

	irpd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_low_us  <= irpd_pkg::RST_ZERO_LOW;
			cfg_q.zero_high_us <= irpd_pkg::RST_ZERO_HIGH;
			cfg_q.one_low_us   <= irpd_pkg::RST_ONE_LOW;
			cfg_q.one_high_us  <= irpd_pkg::RST_ONE_HIGH;
			cfg_q.gap_us       <= irpd_pkg::RST_GAP;
			cfg_q.hold_ms      <= irpd_pkg::RST_HOLD;
			cfg_q.sync_low     <= irpd_pkg::RST_SYNC_LOW;
		end else if (we) begin
			case (index)
				irpd_pkg::REG_ZERO_LOW:  cfg_q.zero_low_us  <= data;
				irpd_pkg::REG_ZERO_HIGH: cfg_q.zero_high_us <= data;
				irpd_pkg::REG_ONE_LOW:   cfg_q.one_low_us   <= data;
				irpd_pkg::REG_ONE_HIGH:  cfg_q.one_high_us  <= data;
				irpd_pkg::REG_GAP:       cfg_q.gap_us       <= data;
				irpd_pkg::REG_HOLD:      cfg_q.hold_ms      <= data;
				irpd_pkg::REG_SYNC_LOW:  cfg_q.sync_low     <= data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> src/irpd_core.sv
// Frame decoder state and its next-state logic for one word per cycle while step is high.
`default_nettype none
module irpd_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic           kind,
	input  wire logic [15:0]    edge_interval_us,
	input  wire logic [31:0]    now_ms,
	input  wire irpd_pkg::cfg_t cfg,
	output logic [15:0]         code_nx,
	output logic                accepted_nx
);

	logic [4:0]  edge_count_q, ec_d;
	logic [7:0]  low_shift_q, ls_d;
	logic [7:0]  high_shift_q, hs_d;
	logic [7:0]  first_low_q, fl_d;
	logic [7:0]  first_high_q, fh_d;
	logic        awaiting_q, aw_d;
	logic [15:0] held_q, held_d;
	logic [31:0] accept_time_q, at_d;
	logic        fresh_q, fresh_d;

	logic [31:0] elapsed;
	logic [4:0]  ec_start;
	logic [4:0]  ec_inc;
	logic [7:0]  ls_new, hs_new;
	logic        is_zero, is_one, bit_val;
	logic        take;

	always_comb begin
		ec_d      = edge_count_q;
		ls_d      = low_shift_q;
		hs_d      = high_shift_q;
		fl_d      = first_low_q;
		fh_d      = first_high_q;
		aw_d      = awaiting_q;
		held_d    = held_q;
		at_d      = accept_time_q;
		fresh_d   = fresh_q;
		take      = 1'b0;
		elapsed   = now_ms - accept_time_q;
		is_zero   = (edge_interval_us > cfg.zero_low_us) &&
			(edge_interval_us < cfg.zero_high_us);
		is_one    = (edge_interval_us > cfg.one_low_us) &&
			(edge_interval_us < cfg.one_high_us);
		// Overlapping windows resolve to bit zero.
		bit_val   = !is_zero;
		ls_new    = low_shift_q;
		hs_new    = high_shift_q;
		ec_start  = edge_count_q;
		ec_inc    = edge_count_q;
		if (kind == irpd_pkg::KIND_READ) begin
			if (elapsed < {16'd0, cfg.hold_ms}) begin
				if (fresh_q) begin
					fresh_d = 1'b0;
					ec_d    = '0;
				end
			end else begin
				held_d = '0;
			end
		end else begin
			// A long interval starts a new frame before this edge counts.
			if (edge_interval_us > cfg.gap_us) begin
				ec_start = '0;
				ls_new   = '0;
				hs_new   = '0;
			end
			ec_inc = ec_start + 5'd1;
			if (ec_start < irpd_pkg::FRAME_EDGES) begin
				if (ec_start[0] && (is_zero || is_one)) begin
					if (ec_start < irpd_pkg::HALF_EDGES)
						ls_new = {ls_new[6:0], bit_val};
					else
						hs_new = {hs_new[6:0], bit_val};
				end
				ec_d = ec_inc;
				ls_d = ls_new;
				hs_d = hs_new;
				if (ec_inc == irpd_pkg::FRAME_EDGES) begin
					if (ls_new == {2'b00, cfg.sync_low}) begin
						take = 1'b1;
					end else if (!awaiting_q) begin
						fl_d = ls_new;
						fh_d = hs_new;
						ec_d = '0;
						ls_d = '0;
						hs_d = '0;
						aw_d = 1'b1;
					end else begin
						aw_d = 1'b0;
						take = (first_low_q == ls_new) && (first_high_q == hs_new);
					end
				end
			end else begin
				ec_d = ec_start;
				ls_d = ls_new;
				hs_d = hs_new;
			end
			if (take) begin
				held_d  = {hs_new, ls_new};
				at_d    = now_ms;
				fresh_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q  <= '0;
			low_shift_q   <= '0;
			high_shift_q  <= '0;
			first_low_q   <= '0;
			first_high_q  <= '0;
			awaiting_q    <= 1'b0;
			held_q        <= '0;
			accept_time_q <= '0;
			fresh_q       <= 1'b0;
		end else if (step) begin
			edge_count_q  <= ec_d;
			low_shift_q   <= ls_d;
			high_shift_q  <= hs_d;
			first_low_q   <= fl_d;
			first_high_q  <= fh_d;
			awaiting_q    <= aw_d;
			held_q        <= held_d;
			accept_time_q <= at_d;
			fresh_q       <= fresh_d;
		end
	end

	assign code_nx     = held_d;
	assign accepted_nx = take;

endmodule
`default_nettype wire

>>> src/irpd_checker.sv
// Port-level assertions for the infrared remote pulse decoder and their bind.
`default_nettype none
module irpd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] code,
	input wire logic        accepted
);

	// A stalled output word keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code) && $stable(accepted))
		else $error("output word changed while stalled");

	// With the output register empty the block always takes input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	// A new output word after an empty cycle comes from an accepted input word that passed the input register.
	a_out_from_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output word without a matching input word");

	// An input word that is taken reaches the output register by way of the input register.
	a_in_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("input word did not reach the output register");

endmodule

bind ir_remote_pulse_decoder irpd_checker u_irpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.code      (code),
	.accepted  (accepted)
);
`default_nettype wire
